/* sv/tss_pkg.sv */
// Constants and tables shared by the Taylor-series sine generator.
package tss_pkg;

    localparam int MAX_TERMS = 10;
    localparam int NUM_UPD   = MAX_TERMS - 1;

    localparam logic [15:0] PI_Q13      = 16'd25736;
    localparam logic [15:0] TWO_PI_Q13  = 16'd51472;
    localparam logic [15:0] HALF_PI_Q13 = 16'd12868;

    localparam logic [7:0] CFG_PERIOD = 8'd0;
    localparam logic [7:0] CFG_TERMS  = 8'd1;

    localparam logic [15:0] PERIOD_DEFAULT = 16'd256;
    localparam logic [3:0]  TERMS_DEFAULT  = 4'd5;

    localparam logic [5:0] RSH [NUM_UPD] = '{
        6'd34, 6'd36, 6'd37, 6'd38, 6'd38, 6'd39, 6'd39, 6'd40, 6'd40
    };

    localparam logic [31:0] RECIP [NUM_UPD] = '{
        32'(((64'd1 << 34) + 64'd5)   / 64'd6),
        32'(((64'd1 << 36) + 64'd19)  / 64'd20),
        32'(((64'd1 << 37) + 64'd41)  / 64'd42),
        32'(((64'd1 << 38) + 64'd71)  / 64'd72),
        32'(((64'd1 << 38) + 64'd109) / 64'd110),
        32'(((64'd1 << 39) + 64'd155) / 64'd156),
        32'(((64'd1 << 39) + 64'd209) / 64'd210),
        32'(((64'd1 << 40) + 64'd271) / 64'd272),
        32'(((64'd1 << 40) + 64'd341) / 64'd342)
    };

endpackage

/* sv/taylor_sine_sample_generator.sv */
// Top level: pipelined Taylor-series sine sample generator.
// Each beat on s_ carries a sample index i; the block returns sin(2*pi*i/N) in
// signed Q2.14 on m_, one result per index, in order. The pipeline is 62
// stages deep (16 for i mod N, one multiply, 16 for the phase division, one
// fold, three per Taylor term update, one output stage), and a new index is
// taken every cycle while the output is drained. A stall on m_ holds the
// whole pipeline. Registers: index 0 period_samples (0 acts as 1), index 1
// term_count (above 10 acts as 10); write them only while the pipeline is
// empty.
module taylor_sine_sample_generator
    import tss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_sample_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_sine_value
);

    logic [15:0] period_reg;
    logic [3:0]  terms_reg;
    logic [15:0] n_eff;
    logic [3:0]  t_eff;
    logic        ce;

    logic        md_v_reg   [16];
    logic [15:0] md_rem_reg [16];
    logic [15:0] md_idx_reg [16];
    logic [15:0] md_rem_next [16];

    logic        mu_v_reg;
    logic [31:0] mu_num_reg;

    logic        dv_v_reg   [16];
    logic [15:0] dv_rem_reg [16];
    logic [15:0] dv_q_reg   [16];
    logic [15:0] dv_lo_reg  [16];
    logic [15:0] dv_rem_next [16];
    logic        dv_bit_next [16];

    logic signed [16:0] x_a, x_b, x_f;
    logic [13:0]        ax;

    logic               c_v_reg   [MAX_TERMS];
    logic [28:0]        c_mag_reg [MAX_TERMS];
    logic [27:0]        c_x2_reg  [MAX_TERMS];
    logic signed [30:0] c_acc_reg [MAX_TERMS];
    logic               c_neg_reg [MAX_TERMS];

    logic               a_v_reg   [NUM_UPD];
    logic [42:0]        a_pa_reg  [NUM_UPD];
    logic [42:0]        a_pb_reg  [NUM_UPD];
    logic [27:0]        a_x2_reg  [NUM_UPD];
    logic signed [30:0] a_acc_reg [NUM_UPD];
    logic               a_neg_reg [NUM_UPD];
    logic [56:0]        a_sum     [NUM_UPD];

    logic               b_v_reg    [NUM_UPD];
    logic [62:0]        b_prod_reg [NUM_UPD];
    logic [27:0]        b_x2_reg   [NUM_UPD];
    logic signed [30:0] b_acc_reg  [NUM_UPD];
    logic               b_neg_reg  [NUM_UPD];
    logic [28:0]        b_mag      [NUM_UPD];

    logic [30:0] o_abs;
    logic [16:0] o_rnd;
    logic signed [15:0] o_val;

    logic        m_valid_reg;
    logic signed [15:0] m_sine_reg;

    assign n_eff   = (period_reg == 16'd0) ? 16'd1 : period_reg;
    assign t_eff   = (terms_reg > 4'(MAX_TERMS)) ? 4'(MAX_TERMS) : terms_reg;
    assign ce      = !m_valid_reg || m_ready;
    assign s_ready = ce;
    assign m_valid = m_valid_reg;
    assign m_sine_value = m_sine_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_DEFAULT;
            terms_reg  <= TERMS_DEFAULT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PERIOD: period_reg <= cfg_data;
                CFG_TERMS:  terms_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // restoring division steps
    always_comb begin
        logic [16:0] t;
        logic [16:0] u;
        for (int k = 0; k < 16; k++) begin
            t = (k == 0) ? {16'd0, s_sample_index[15]}
                         : {md_rem_reg[k-1], md_idx_reg[k-1][15-k]};
            md_rem_next[k] = (t >= {1'b0, n_eff}) ? 16'(t - {1'b0, n_eff}) : t[15:0];
            u = (k == 0) ? {mu_num_reg[31:16], mu_num_reg[15]}
                         : {dv_rem_reg[k-1], dv_lo_reg[k-1][15-k]};
            dv_bit_next[k] = (u >= {1'b0, n_eff});
            dv_rem_next[k] = dv_bit_next[k] ? 16'(u - {1'b0, n_eff}) : u[15:0];
        end
    end

    always_comb begin
        x_a = signed'({1'b0, dv_q_reg[15]});
        if (x_a > signed'({1'b0, PI_Q13})) begin
            x_b = x_a - signed'({1'b0, TWO_PI_Q13});
        end else begin
            x_b = x_a;
        end
        if (x_b > signed'({1'b0, HALF_PI_Q13})) begin
            x_f = signed'({1'b0, PI_Q13}) - x_b;
        end else if (x_b < -signed'({1'b0, HALF_PI_Q13})) begin
            x_f = -signed'({1'b0, PI_Q13}) - x_b;
        end else begin
            x_f = x_b;
        end
        ax = x_f[16] ? 14'(-x_f) : x_f[13:0];
    end

    always_comb begin
        for (int j = 0; j < NUM_UPD; j++) begin
            a_sum[j] = {a_pa_reg[j], 14'd0} + 57'(a_pb_reg[j]);
            b_mag[j] = 29'(b_prod_reg[j] >> RSH[j]);
        end
    end

    always_comb begin
        o_abs = c_acc_reg[MAX_TERMS-1][30] ? 31'(-c_acc_reg[MAX_TERMS-1])
                                           : c_acc_reg[MAX_TERMS-1];
        o_rnd = 17'((o_abs + 31'd8192) >> 14);
        if (c_acc_reg[MAX_TERMS-1][30]) begin
            o_val = (o_rnd > 17'd32768) ? 16'sh8000 : 16'(-o_rnd);
        end else begin
            o_val = (o_rnd > 17'd32767) ? 16'sh7fff : o_rnd[15:0];
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 16; k++) begin
                md_v_reg[k] <= 1'b0;
                dv_v_reg[k] <= 1'b0;
            end
            mu_v_reg <= 1'b0;
            for (int j = 0; j < MAX_TERMS; j++) begin
                c_v_reg[j] <= 1'b0;
            end
            for (int j = 0; j < NUM_UPD; j++) begin
                a_v_reg[j] <= 1'b0;
                b_v_reg[j] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            md_v_reg[0] <= s_valid;
            dv_v_reg[0] <= mu_v_reg;
            for (int k = 1; k < 16; k++) begin
                md_v_reg[k] <= md_v_reg[k-1];
                dv_v_reg[k] <= dv_v_reg[k-1];
            end
            mu_v_reg   <= md_v_reg[15];
            c_v_reg[0] <= dv_v_reg[15];
            for (int j = 0; j < NUM_UPD; j++) begin
                a_v_reg[j]   <= c_v_reg[j];
                b_v_reg[j]   <= a_v_reg[j];
                c_v_reg[j+1] <= b_v_reg[j];
            end
            m_valid_reg <= c_v_reg[MAX_TERMS-1];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (ce) begin
            md_rem_reg[0] <= md_rem_next[0];
            md_idx_reg[0] <= s_sample_index;
            dv_rem_reg[0] <= dv_rem_next[0];
            dv_q_reg[0]   <= {15'd0, dv_bit_next[0]};
            dv_lo_reg[0]  <= mu_num_reg[15:0];
            for (int k = 1; k < 16; k++) begin
                md_rem_reg[k] <= md_rem_next[k];
                md_idx_reg[k] <= md_idx_reg[k-1];
                dv_rem_reg[k] <= dv_rem_next[k];
                dv_q_reg[k]   <= {dv_q_reg[k-1][14:0], dv_bit_next[k]};
                dv_lo_reg[k]  <= dv_lo_reg[k-1];
            end
            mu_num_reg <= 32'(md_rem_reg[15]) * 32'(TWO_PI_Q13) + 32'(n_eff >> 1);

            c_mag_reg[0] <= {ax, 15'd0};
            c_x2_reg[0]  <= 28'(ax) * 28'(ax);
            c_neg_reg[0] <= x_f[16];
            if (t_eff == 4'd0) begin
                c_acc_reg[0] <= '0;
            end else if (x_f[16]) begin
                c_acc_reg[0] <= -signed'({2'b0, ax, 15'd0});
            end else begin
                c_acc_reg[0] <= signed'({2'b0, ax, 15'd0});
            end

            for (int j = 0; j < NUM_UPD; j++) begin
                a_pa_reg[j]  <= 43'(c_mag_reg[j]) * 43'(c_x2_reg[j][27:14]);
                a_pb_reg[j]  <= 43'(c_mag_reg[j]) * 43'(c_x2_reg[j][13:0]);
                a_x2_reg[j]  <= c_x2_reg[j];
                a_acc_reg[j] <= c_acc_reg[j];
                a_neg_reg[j] <= c_neg_reg[j];

                b_prod_reg[j] <= 63'(a_sum[j][56:26]) * 63'(RECIP[j]);
                b_x2_reg[j]   <= a_x2_reg[j];
                b_acc_reg[j]  <= a_acc_reg[j];
                b_neg_reg[j]  <= a_neg_reg[j];

                c_mag_reg[j+1] <= b_mag[j];
                c_x2_reg[j+1]  <= b_x2_reg[j];
                c_neg_reg[j+1] <= b_neg_reg[j];
                if (4'(j + 1) >= t_eff) begin
                    c_acc_reg[j+1] <= b_acc_reg[j];
                end else if (b_neg_reg[j] ^ (((j + 1) % 2) == 1)) begin
                    c_acc_reg[j+1] <= b_acc_reg[j] - signed'({2'b0, b_mag[j]});
                end else begin
                    c_acc_reg[j+1] <= b_acc_reg[j] + signed'({2'b0, b_mag[j]});
                end
            end
            m_sine_reg <= o_val;
        end
    end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the Taylor-series sine sample generator.
`timescale 1ns / 100ps

module testbench;
    import tss_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_sample_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [15:0] m_sine_value;

    logic [15:0] period_reg;
    logic [3:0]  terms_reg;
    logic [15:0] index_pending [$];
    logic signed [15:0] sine_expected [$];
    int          mismatches = 0;
    int          sines_checked = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_phase = 0;
    logic        feed_enable = 1'b0;

    taylor_sine_sample_generator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample_index(s_sample_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_sine_value(m_sine_value)
    );

    always #1 aclk = ~aclk;

    function automatic logic signed [15:0] taylor_sine(input logic [15:0] idx);
        longint unsigned n, r, ax, x2, mag, amag;
        longint          x, acc, y;
        int              terms;
        bit              neg_x, neg;
        n = (period_reg == 0) ? 1 : period_reg;
        r = idx % n;
        x = (64'(TWO_PI_Q13) * r + n / 2) / n;
        if (x > longint'(PI_Q13)) x -= longint'(TWO_PI_Q13);
        if (x > longint'(HALF_PI_Q13)) x = longint'(PI_Q13) - x;
        if (x < -longint'(HALF_PI_Q13)) x = -longint'(PI_Q13) - x;
        neg_x = x < 0;
        ax = neg_x ? -x : x;
        x2 = ax * ax;
        mag = ax << 15;
        acc = 0;
        terms = (terms_reg > MAX_TERMS) ? MAX_TERMS : terms_reg;
        for (int j = 0; j < terms; j++) begin
            neg = neg_x ^ j[0];
            if (neg) acc -= mag;
            else acc += mag;
            mag = ((mag * x2) >> 26) / ((2 * j + 2) * (2 * j + 3));
        end
        amag = (acc < 0) ? -acc : acc;
        amag = (amag + 8192) >> 14;
        y = (acc < 0) ? -longint'(amag) : longint'(amag);
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        return y[15:0];
    endfunction

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_PERIOD) period_reg = val;
        else if (idx == CFG_TERMS) terms_reg = val[3:0];
    endtask

    task automatic run_phase(input logic [15:0] per, input logic [3:0] trm, input int count);
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_TERMS, trm);
        write_reg(8'd7, 16'hFFFF);
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 3))
                0: index_pending.push_back(16'($urandom));
                1: index_pending.push_back(16'($urandom_range(0, 3)) * (per >> 2));
                default: index_pending.push_back(16'($urandom_range(0, per)));
            endcase
        end
        wait (index_pending.size() == 0 && !s_valid && sine_expected.size() == 0);
        repeat (80) @(posedge aclk);
    endtask

    // driver: bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
        end else begin
            if (s_valid) begin
                sine_expected.push_back(taylor_sine(s_sample_index));
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (feed_enable && index_pending.size() > 0) begin
                s_valid <= 1'b1;
                s_sample_index <= index_pending.pop_front();
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: stall pattern on m_ready
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        stall_phase <= (stall_phase + 1) % 256;
        m_ready <= (stall_phase < 96) ? 1'b1 : ($urandom_range(0, 3) != 0);
        if (aresetn && m_valid && m_ready) begin
            if (sine_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: sine %0d", m_sine_value);
            end else begin
                logic signed [15:0] exp_sine;
                exp_sine = sine_expected.pop_front();
                sines_checked++;
                if (exp_sine !== m_sine_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sine mismatch: expected %0d actual %0d", exp_sine, m_sine_value);
                end
            end
        end
        if (cycle_count > 400000) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        period_reg = PERIOD_DEFAULT;
        terms_reg  = TERMS_DEFAULT;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        feed_enable = 1'b1;
        // directed: reset config, extremes, each special case
        index_pending.push_back(16'd0);
        index_pending.push_back(16'd64);
        index_pending.push_back(16'd128);
        index_pending.push_back(16'd192);
        index_pending.push_back(16'd255);
        index_pending.push_back(16'hFFFF);
        index_pending.push_back(16'd32768);
        wait (index_pending.size() == 0 && !s_valid && sine_expected.size() == 0);
        repeat (80) @(posedge aclk);
        run_phase(16'd0, 4'd5, 4);
        run_phase(16'd4, 4'd0, 4);
        run_phase(16'd4, 4'd15, 6);
        run_phase(16'd1, 4'd10, 3);
        run_phase(16'hFFFF, 4'd1, 4);
        // random phases
        run_phase(16'd256, 4'd5, 150);
        run_phase(16'd360, 4'd10, 150);
        run_phase(16'hFFFF, 4'd12, 150);
        run_phase(16'd7, 4'd2, 100);
        run_phase(16'($urandom_range(1, 65535)), 4'($urandom_range(0, 15)), 150);
        run_phase(16'($urandom_range(2, 1000)), 4'd1, 100);
        run_phase(16'h8000, 4'd3, 100);
        $display("Checked %0d sine samples over 13 register settings, %0d mismatches",
                 sines_checked, mismatches);
        if (mismatches == 0 && sine_expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* taylor_sine_sample_generator.f */
sv/tss_pkg.sv
sv/taylor_sine_sample_generator.sv
sim/testbench.sv
